// ===== src/cle_pkg.sv =====
package cle_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_START     = 4'd0;
  localparam logic [OP_W-1:0] OP_END       = 4'd1;
  localparam logic [OP_W-1:0] OP_NEXT      = 4'd2;
  localparam logic [OP_W-1:0] OP_PRIOR     = 4'd3;
  localparam logic [OP_W-1:0] OP_INS_AHEAD = 4'd4;
  localparam logic [OP_W-1:0] OP_INS_AFTER = 4'd5;
  localparam logic [OP_W-1:0] OP_REMOVE    = 4'd6;
  localparam logic [OP_W-1:0] OP_READ      = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] value;
  } cle_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     is_full;
  } cle_out_t;

endpackage

// ===== src/cursor_list_engine_core.sv =====
// Ordered list of up to DEPTH signed 32-bit words with a cursor, kept in one
// single-port-write, single-port-read RAM with registered read data. Every
// request returns one result. Cursor moves, clear, refused requests and an
// insert into an empty list go from idle straight to the done state, where the
// result is written to the output register. A read passes through the read
// state first, and an insert or remove through the shift states. Insert and
// remove move the words behind the cursor one place per cycle through the RAM.
// A new request is taken only once the previous one has finished its RAM work.
// A finished result waits in the output register while the next request is
// accepted. A result that is still waiting there when the next one finishes
// holds that one back.
module cursor_list_engine_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cle_pkg::cle_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cle_pkg::cle_out_t  out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UP,
    S_DOWN,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               cur_q, cur_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               wa_q, wa_d;
  logic                        pend_q, pend_d;
  logic [cle_pkg::WORD_W-1:0]  val_q, val_d;
  logic                        ok_q, ok_d;
  logic [cle_pkg::WORD_W-1:0]  rd_q, rd_d;
  logic                        out_valid_q, out_valid_d;
  cle_pkg::cle_out_t           out_q, out_d;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [cle_pkg::WORD_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [cle_pkg::WORD_W-1:0]  mem_rdata;

  logic                        in_xfer;
  logic                        empty;
  logic [AW-1:0]               last;
  logic                        out_free;

  cle_word_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign last       = empty ? '0 : AW'(count_q - CW'(1));
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    wa_d        = wa_q;
    pend_d      = pend_q;
    val_d       = val_q;
    ok_d        = ok_q;
    rd_d        = rd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = wa_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          ok_d    = 1'b0;
          rd_d    = '0;
          pend_d  = 1'b0;
          state_d = S_DONE;
          unique case (in_data_i.operation)
            cle_pkg::OP_START: begin
              if (!empty && cur_q != '0) begin
                cur_d = '0;
                ok_d  = 1'b1;
              end
            end
            cle_pkg::OP_END: begin
              if (!empty && cur_q != last) begin
                cur_d = last;
                ok_d  = 1'b1;
              end
            end
            cle_pkg::OP_NEXT: begin
              if (!empty && cur_q != last) begin
                cur_d = cur_q + AW'(1);
                ok_d  = 1'b1;
              end
            end
            cle_pkg::OP_PRIOR: begin
              if (!empty && cur_q != '0) begin
                cur_d = cur_q - AW'(1);
                ok_d  = 1'b1;
              end
            end
            cle_pkg::OP_INS_AHEAD, cle_pkg::OP_INS_AFTER: begin
              if (count_q < FULL_COUNT) begin
                ok_d = 1'b1;
                if (empty) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = in_data_i.value;
                  count_d   = CW'(1);
                  cur_d     = '0;
                end else begin
                  // The new word lands at the cursor; insert after steps past the old word.
                  val_d   = in_data_i.value;
                  idx_d   = AW'(count_q);
                  state_d = S_UP;
                  if (in_data_i.operation == cle_pkg::OP_INS_AFTER) begin
                    cur_d = cur_q + AW'(1);
                  end
                end
              end
            end
            cle_pkg::OP_REMOVE: begin
              if (!empty) begin
                ok_d    = 1'b1;
                idx_d   = cur_q;
                state_d = S_DOWN;
              end
            end
            cle_pkg::OP_READ: begin
              if (!empty) begin
                ok_d      = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = cur_q;
                state_d   = S_READ;
              end
            end
            cle_pkg::OP_CLEAR: begin
              count_d = '0;
              cur_d   = '0;
              ok_d    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        rd_d    = mem_rdata;
        state_d = S_DONE;
      end

      // Walk down from the top: read entry idx-1, write it to idx in the next cycle.
      S_UP: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = mem_rdata;
        end
        if (idx_q != cur_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - AW'(1);
          wa_d      = idx_q;
          idx_d     = idx_q - AW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = cur_q;
            mem_wdata = val_q;
            count_d   = count_q + CW'(1);
            state_d   = S_DONE;
          end
        end
      end

      // Walk up from the cursor: read entry idx+1, write it to idx in the next cycle.
      S_DOWN: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = mem_rdata;
        end
        if ((CW'(idx_q) + CW'(1)) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + AW'(1);
          wa_d      = idx_q;
          idx_d     = idx_q + AW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (cur_q >= last) begin
              cur_d = '0;
            end
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_d.ok         = ok_q;
          out_d.read_value = rd_q;
          out_d.count      = cle_pkg::COUNT_W'(count_q);
          out_d.is_empty   = empty;
          out_d.is_full    = (count_q == FULL_COUNT);
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    wa_q  <= wa_d;
    val_q <= val_d;
    ok_q  <= ok_d;
    rd_q  <= rd_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/cle_word_ram.sv =====
module cle_word_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic [cle_pkg::WORD_W-1:0]        wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic [cle_pkg::WORD_W-1:0]        rdata_o
);

  logic [cle_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [cle_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
